FILE: hdl/vnorm_pkg.sv
// Shared types and constants for the four-component vector normalizer.
package vnorm_pkg;

   localparam int SQRT_IN_W  = 34;   // squared magnitude width seen by the root unit
   localparam int MAG_W      = 17;   // Q9.8 magnitude, saturated
   localparam int UNIT_W     = 16;   // Q2.14 output component
   localparam int QUO_W      = 16;   // quotient bits produced by the divider
   localparam int LANES      = 4;
   localparam int UNIT_SHIFT = 14;

   localparam logic [MAG_W-1:0]  MAG_MAX  = 17'h1FFFF;
   localparam logic [UNIT_W-1:0] UNIT_POS = 16'h7FFF;
   localparam logic [QUO_W-1:0]  UNIT_NEG = 16'h8000;

   // Per-lane divider state.
   typedef struct packed {
      logic                 neg;
      logic                 ovf;
      logic [SQRT_IN_W-1:0] rem;
      logic [QUO_W-1:0]     quo;
   } lane_type;

   // Per-transaction control traveling with the divider lanes.
   typedef struct packed {
      logic             valid;
      logic             is_zero;
      logic [MAG_W-1:0] mag;
   } ctl_type;

endpackage

FILE: hdl/vnorm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module vnorm_sqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic [vnorm_pkg::SQRT_IN_W-1:0]    in_val,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic [vnorm_pkg::MAG_W-1:0]        out_root,
   output logic [SIDE_W-1:0]                  out_side
);

   localparam int STEPS = vnorm_pkg::MAG_W;
   localparam int RES_W = vnorm_pkg::SQRT_IN_W + 1;

   logic [vnorm_pkg::SQRT_IN_W-1:0] rem_d  [0:STEPS];
   logic [RES_W-1:0]                res_d  [0:STEPS];
   logic                            vld_d  [0:STEPS];
   logic [SIDE_W-1:0]               side_d [0:STEPS];

   assign rem_d[0]  = in_val;
   assign res_d[0]  = '0;
   assign vld_d[0]  = in_valid;
   assign side_d[0] = in_side;

   genvar j;
   generate
      for (j = 0; j < STEPS; j++) begin : g_step
         localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (STEPS - 1 - j));
         logic [RES_W-1:0]                trial;
         logic [vnorm_pkg::SQRT_IN_W-1:0] rem_in, rem_ff;
         logic [RES_W-1:0]                res_in, res_ff;
         logic                            vld_ff;
         logic [SIDE_W-1:0]               side_ff;

         always_comb begin
            trial = res_d[j] + BIT;
            if ({1'b0, rem_d[j]} >= trial) begin
               rem_in = rem_d[j] - trial[vnorm_pkg::SQRT_IN_W-1:0];
               res_in = (res_d[j] >> 1) + BIT;
            end else begin
               rem_in = rem_d[j];
               res_in = res_d[j] >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff <= 1'b0;
            end else if (adv) begin
               vld_ff <= vld_d[j];
            end
            if (adv) begin
               rem_ff  <= rem_in;
               res_ff  <= res_in;
               side_ff <= side_d[j];
            end
         end

         assign rem_d[j+1]  = rem_ff;
         assign res_d[j+1]  = res_ff;
         assign vld_d[j+1]  = vld_ff;
         assign side_d[j+1] = side_ff;
      end
   endgenerate

   assign out_valid = vld_d[STEPS];
   assign out_root  = res_d[STEPS][vnorm_pkg::MAG_W-1:0];
   assign out_side  = side_d[STEPS];

endmodule

FILE: hdl/vnorm_div.sv
// Zero test, pipelined restoring divider and saturation for the four lanes.
module vnorm_div #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [vnorm_pkg::MAG_W-1:0]       in_root,
   input  logic                              in_sat,
   input  logic [COMPONENT_BITS-1:0]         in_abs [0:vnorm_pkg::LANES-1],
   input  logic [vnorm_pkg::LANES-1:0]       in_neg,
   input  logic [15:0]                       zero_margin,
   output logic                              out_valid,
   output logic signed [vnorm_pkg::UNIT_W-1:0] out_unit [0:vnorm_pkg::LANES-1],
   output logic [vnorm_pkg::MAG_W-1:0]       out_mag,
   output logic                              out_is_zero
);

   localparam int LANES = vnorm_pkg::LANES;
   localparam int QW    = vnorm_pkg::QUO_W;
   localparam int RW    = vnorm_pkg::SQRT_IN_W;
   localparam int DW    = vnorm_pkg::MAG_W + 1;
   localparam int NUM_W = COMPONENT_BITS + vnorm_pkg::UNIT_SHIFT + 2;
   localparam int EXT_W = (NUM_W > RW) ? NUM_W : RW;
   localparam int HI_W  = (COMPONENT_BITS > DW) ? COMPONENT_BITS : DW;

   vnorm_pkg::ctl_type  ctl_d  [0:QW+1];
   vnorm_pkg::lane_type lane_d [0:QW+1][0:LANES-1];

   // Setup stage: magnitude, zero test, numerator and overflow check.
   vnorm_pkg::ctl_type  pre_ctl_in, pre_ctl_ff;
   vnorm_pkg::lane_type pre_lane_in [0:LANES-1];
   vnorm_pkg::lane_type pre_lane_ff [0:LANES-1];
   logic [DW-1:0]       den;

   always_comb begin
      pre_ctl_in.valid   = in_valid;
      pre_ctl_in.mag     = in_sat ? vnorm_pkg::MAG_MAX : in_root;
      pre_ctl_in.is_zero = (pre_ctl_in.mag <= {1'b0, zero_margin});
      den = {pre_ctl_in.mag, 1'b0};
   end

   genvar l, s;
   generate
      for (l = 0; l < LANES; l++) begin : g_pre
         logic [NUM_W-1:0] num;
         logic [EXT_W-1:0] num_ext;
         always_comb begin
            num = (NUM_W'(in_abs[l]) << (vnorm_pkg::UNIT_SHIFT + 1))
                  + NUM_W'(pre_ctl_in.mag);
            num_ext = EXT_W'(num);
            pre_lane_in[l].neg = in_neg[l];
            // quotient of 2^16 or more is certain to saturate
            pre_lane_in[l].ovf = HI_W'(num[NUM_W-1:QW]) >= HI_W'(den);
            pre_lane_in[l].rem = num_ext[RW-1:0];
            pre_lane_in[l].quo = '0;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               pre_lane_ff[l] <= pre_lane_in[l];
            end
         end
         assign lane_d[0][l] = pre_lane_ff[l];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         pre_ctl_ff.valid <= pre_ctl_in.valid;
      end
      if (adv) begin
         pre_ctl_ff.mag     <= pre_ctl_in.mag;
         pre_ctl_ff.is_zero <= pre_ctl_in.is_zero;
      end
   end
   assign ctl_d[0] = pre_ctl_ff;

   // One quotient bit per stage, most significant first.
   generate
      for (s = 0; s < QW; s++) begin : g_stage
         vnorm_pkg::ctl_type ctl_ff;
         logic [RW-1:0]      dsh;
         assign dsh = RW'({ctl_d[s].mag, 1'b0}) << (QW - 1 - s);

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff.valid <= 1'b0;
            end else if (adv) begin
               ctl_ff.valid <= ctl_d[s].valid;
            end
            if (adv) begin
               ctl_ff.mag     <= ctl_d[s].mag;
               ctl_ff.is_zero <= ctl_d[s].is_zero;
            end
         end
         assign ctl_d[s+1] = ctl_ff;

         for (l = 0; l < LANES; l++) begin : g_lane
            vnorm_pkg::lane_type lane_in, lane_ff;
            always_comb begin
               lane_in = lane_d[s][l];
               if (lane_d[s][l].rem >= dsh) begin
                  lane_in.rem = lane_d[s][l].rem - dsh;
                  lane_in.quo[QW-1-s] = 1'b1;
               end
            end
            always_ff @(posedge clock) begin
               if (adv) begin
                  lane_ff <= lane_in;
               end
            end
            assign lane_d[s+1][l] = lane_ff;
         end
      end
   endgenerate

   // Final stage: saturate, apply sign, zero when inside the margin.
   vnorm_pkg::ctl_type ctl_fin_ff;
   logic [vnorm_pkg::UNIT_W-1:0] unit_in [0:LANES-1];
   logic [vnorm_pkg::UNIT_W-1:0] unit_ff [0:LANES-1];

   generate
      for (l = 0; l < LANES; l++) begin : g_fin
         vnorm_pkg::lane_type ln;
         assign ln = lane_d[QW][l];
         always_comb begin
            if (ctl_d[QW].is_zero) begin
               unit_in[l] = '0;
            end else if (ln.neg) begin
               if (ln.ovf || ln.quo > vnorm_pkg::UNIT_NEG) begin
                  unit_in[l] = vnorm_pkg::UNIT_NEG;
               end else begin
                  unit_in[l] = 16'(-ln.quo);
               end
            end else if (ln.ovf || ln.quo > vnorm_pkg::UNIT_POS) begin
               unit_in[l] = vnorm_pkg::UNIT_POS;
            end else begin
               unit_in[l] = ln.quo;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               unit_ff[l] <= unit_in[l];
            end
         end
         assign out_unit[l] = signed'(unit_ff[l]);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_fin_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_fin_ff.valid <= ctl_d[QW].valid;
      end
      if (adv) begin
         ctl_fin_ff.is_zero <= ctl_d[QW].is_zero;
         ctl_fin_ff.mag     <= ctl_d[QW].is_zero ? '0 : ctl_d[QW].mag;
      end
   end

   assign out_valid   = ctl_fin_ff.valid;
   assign out_mag     = ctl_fin_ff.mag;
   assign out_is_zero = ctl_fin_ff.is_zero;

endmodule

FILE: hdl/vec4_normalize_core.sv
// Top level of the four-component vector normalizer.
//
// Usage:
//  - req_ channel (valid/stall): one vector per transaction, mode, four signed
//    components with 8 fraction bits, and a Q16.16 squared magnitude used in mode 1.
//  - rsp_ channel (valid/stall): one result per request, four Q2.14 unit components,
//    the Q9.8 magnitude and a zero flag; results come out in request order.
//  - csr_ channel (valid/ready): writes zero_margin; always ready. Write only while
//    no transaction is in flight.
// Timing:
//  - From request acceptance to rsp_valid a result passes three input
//    stages (abs, square, sum), 17 square-root stages, 17 divider stages
//    (setup plus one quotient bit per stage), one finish stage, one output register.
//  - Throughput is one transaction per cycle while req_stall is low; the
//    bit-per-stage root and divider pipelines set the depth, not the rate.
// Reset (synchronous): clears all valid bits and sets zero_margin to 1.
// Backpressure: when rsp_stall holds a result, the pipeline keeps running until
//  its last stage lands in a one-entry skid buffer; req_stall rises only while
//  that buffer is full, and the whole pipeline freezes with nothing lost.
module vec4_normalize_core #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic signed [COMPONENT_BITS-1:0] req_comp_x,
   input  logic signed [COMPONENT_BITS-1:0] req_comp_y,
   input  logic signed [COMPONENT_BITS-1:0] req_comp_z,
   input  logic signed [COMPONENT_BITS-1:0] req_comp_w,
   input  logic [31:0]                      req_given_mag_sq,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [15:0]               rsp_unit_x,
   output logic signed [15:0]               rsp_unit_y,
   output logic signed [15:0]               rsp_unit_z,
   output logic signed [15:0]               rsp_unit_w,
   output logic [16:0]                      rsp_magnitude,
   output logic                             rsp_is_zero,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [15:0]                      csr_zero_margin
);

   localparam int CB     = COMPONENT_BITS;
   localparam int LANES  = vnorm_pkg::LANES;
   localparam int SQ_W   = 2 * CB;
   localparam int SUM_W  = (2 * CB + 2 > vnorm_pkg::SQRT_IN_W + 1) ?
                           2 * CB + 2 : vnorm_pkg::SQRT_IN_W + 1;
   localparam int SIDE_W = 1 + LANES + LANES * CB;

   // Config register
   logic [15:0] zero_margin_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_margin_ff <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         zero_margin_ff <= csr_zero_margin;
      end
   end

   // Pipeline advances whenever the skid slot is free.
   logic skid_valid_ff;
   logic adv;
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 1: sign and magnitude of each component.
   logic signed [CB-1:0] comp [0:LANES-1];
   assign comp[0] = req_comp_x;
   assign comp[1] = req_comp_y;
   assign comp[2] = req_comp_z;
   assign comp[3] = req_comp_w;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_mode_ff, s2_mode_ff;
   logic [31:0]       s1_given_ff, s2_given_ff;
   logic [CB-1:0]     s1_abs_ff [0:LANES-1];
   logic [LANES-1:0]  s1_neg_ff;
   logic [CB-1:0]     s2_abs_ff [0:LANES-1];
   logic [LANES-1:0]  s2_neg_ff;
   logic [SQ_W-1:0]   s2_sq_ff  [0:LANES-1];
   logic [SIDE_W-1:0] s3_side_ff;
   logic [vnorm_pkg::SQRT_IN_W-1:0] s3_magsq_ff;
   logic [SUM_W-1:0]  sum_in;
   logic              sat_in;

   genvar l;
   generate
      for (l = 0; l < LANES; l++) begin : g_front
         always_ff @(posedge clock) begin
            if (adv) begin
               s1_neg_ff[l] <= comp[l][CB-1];
               s1_abs_ff[l] <= comp[l][CB-1] ? CB'(-comp[l]) : CB'(comp[l]);
               s2_abs_ff[l] <= s1_abs_ff[l];
               s2_neg_ff[l] <= s1_neg_ff[l];
               s2_sq_ff[l]  <= SQ_W'(s1_abs_ff[l]) * SQ_W'(s1_abs_ff[l]);
            end
         end
      end
   endgenerate

   // Stage 3: sum of squares or supplied value; roots above 0x1FFFF saturate.
   always_comb begin
      sum_in = SUM_W'(s2_sq_ff[0]) + SUM_W'(s2_sq_ff[1])
             + SUM_W'(s2_sq_ff[2]) + SUM_W'(s2_sq_ff[3]);
      if (s2_mode_ff) begin
         sum_in = SUM_W'(s2_given_ff);
      end
      sat_in = |sum_in[SUM_W-1:vnorm_pkg::SQRT_IN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s1_mode_ff  <= req_mode;
         s1_given_ff <= req_given_mag_sq;
         s2_mode_ff  <= s1_mode_ff;
         s2_given_ff <= s1_given_ff;
         s3_magsq_ff <= sum_in[vnorm_pkg::SQRT_IN_W-1:0];
         s3_side_ff  <= {sat_in, s2_neg_ff, s2_abs_ff[0], s2_abs_ff[1],
                         s2_abs_ff[2], s2_abs_ff[3]};
      end
   end

   // Square root
   logic                        rt_valid;
   logic [vnorm_pkg::MAG_W-1:0] rt_root;
   logic [SIDE_W-1:0]           rt_side;

   vnorm_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s3_valid_ff),
      .in_val    (s3_magsq_ff),
      .in_side   (s3_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   logic [CB-1:0] rt_abs [0:LANES-1];
   assign rt_abs[0] = rt_side[4*CB-1:3*CB];
   assign rt_abs[1] = rt_side[3*CB-1:2*CB];
   assign rt_abs[2] = rt_side[2*CB-1:CB];
   assign rt_abs[3] = rt_side[CB-1:0];

   // Divide and saturate
   logic                        dv_valid;
   logic signed [15:0]          dv_unit [0:LANES-1];
   logic [vnorm_pkg::MAG_W-1:0] dv_mag;
   logic                        dv_is_zero;

   vnorm_div #(.COMPONENT_BITS(CB)) u_div (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (rt_valid),
      .in_root     (rt_root),
      .in_sat      (rt_side[SIDE_W-1]),
      .in_abs      (rt_abs),
      .in_neg      (rt_side[SIDE_W-2:LANES*CB]),
      .zero_margin (zero_margin_ff),
      .out_valid   (dv_valid),
      .out_unit    (dv_unit),
      .out_mag     (dv_mag),
      .out_is_zero (dv_is_zero)
   );

   // Output register plus one-entry skid buffer.
   localparam int RSP_W = 4 * 16 + vnorm_pkg::MAG_W + 1;
   logic [RSP_W-1:0] pipe_rsp, skid_ff, out_ff;
   logic             rsp_valid_ff;
   logic             out_load;

   assign pipe_rsp = {dv_unit[0], dv_unit[1], dv_unit[2], dv_unit[3], dv_mag, dv_is_zero};
   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff  <= skid_valid_ff || dv_valid;
         skid_valid_ff <= 1'b0;
      end else if (adv && dv_valid) begin
         skid_valid_ff <= 1'b1;
      end
      if (out_load) begin
         out_ff <= skid_valid_ff ? skid_ff : pipe_rsp;
      end else if (adv) begin
         skid_ff <= pipe_rsp;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_unit_x    = signed'(out_ff[RSP_W-1 -: 16]);
   assign rsp_unit_y    = signed'(out_ff[RSP_W-17 -: 16]);
   assign rsp_unit_z    = signed'(out_ff[RSP_W-33 -: 16]);
   assign rsp_unit_w    = signed'(out_ff[RSP_W-49 -: 16]);
   assign rsp_magnitude = out_ff[vnorm_pkg::MAG_W:1];
   assign rsp_is_zero   = out_ff[0];

   // Skid slot is only ever filled behind a held result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry without a held result");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled while output was free");

   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_zero |-> rsp_magnitude == 17'd0 && rsp_unit_x == 16'sd0
         && rsp_unit_y == 16'sd0 && rsp_unit_z == 16'sd0 && rsp_unit_w == 16'sd0)
      else $error("zero result with nonzero fields");

   a_margin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_zero |-> rsp_magnitude > {1'b0, zero_margin_ff})
      else $error("magnitude within margin not flagged");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the four-component vector normalizer.
module testbench;

   // One request transaction as the driver presents it.
   typedef struct {
      logic              mode;
      logic signed [15:0] cx, cy, cz, cw;
      logic [31:0]       given;
   } vec_item_type;

   // One result transaction as the normalizer should return it.
   typedef struct {
      logic signed [vnorm_pkg::UNIT_W-1:0] ux, uy, uz, uw;
      logic [vnorm_pkg::MAG_W-1:0]         mag;
      logic                                zero;
   } unit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic signed [15:0] req_comp_x = '0, req_comp_y = '0, req_comp_z = '0, req_comp_w = '0;
   logic [31:0] req_given_mag_sq = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_unit_w;
   logic [16:0] rsp_magnitude;
   logic rsp_is_zero;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_zero_margin = '0;

   vec_item_type    pending_vecs[$];
   unit_result_type expected_units[$];
   logic [15:0] margin = 16'd1;     // predictor's copy of zero_margin
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;          // sender idle chance, percent
   int  recv_idle_pct = 0;          // receiver stall chance, percent
   bit  hold_sender = 1'b0;         // pause the driver without draining the queue
   bit  req_taken = 1'b0;           // request accepted at the last rising edge

   localparam int CYCLE_LIMIT = 400000;

   vec4_normalize_core DUT (.*);

   always #1 clock = ~clock;

   // Floor integer square root of a 64-bit value.
   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root, bit_pos;
      root = 0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos >>= 2;
      while (bit_pos != 0) begin
         if (v >= root + bit_pos) begin
            v -= root + bit_pos;
            root = (root >> 1) + bit_pos;
         end else begin
            root >>= 1;
         end
         bit_pos >>= 2;
      end
      return root;
   endfunction

   // comp * 2^14 / mag, nearest with ties away from zero, then clamped to Q2.14.
   function automatic logic [15:0] scale_lane(logic signed [15:0] c, logic [63:0] mag);
      logic [63:0] a, q;
      a = c[15] ? 64'(-33'(c)) : 64'(c);
      q = ((a << (vnorm_pkg::UNIT_SHIFT + 1)) + mag) / (mag << 1);
      if (c[15]) begin
         if (q > 64'd32768) q = 64'd32768;
         return 16'(-q);
      end
      if (q > 64'd32767) q = 64'd32767;
      return q[15:0];
   endfunction

   // Expected normalizer output for one vector under the current margin.
   function automatic unit_result_type normalize_vec(vec_item_type v);
      unit_result_type r;
      logic [63:0] sq, mag;
      sq = 64'(v.cx) * 64'(v.cx) + 64'(v.cy) * 64'(v.cy)
         + 64'(v.cz) * 64'(v.cz) + 64'(v.cw) * 64'(v.cw);
      if (v.mode) sq = 64'(v.given);
      mag = floor_sqrt(sq);
      if (mag > 64'(vnorm_pkg::MAG_MAX)) mag = 64'(vnorm_pkg::MAG_MAX);
      r = '{default: '0};
      if (mag <= 64'(margin)) begin
         r.zero = 1'b1;
         return r;
      end
      r.ux = scale_lane(v.cx, mag);
      r.uy = scale_lane(v.cy, mag);
      r.uz = scale_lane(v.cz, mag);
      r.uw = scale_lane(v.cw, mag);
      r.mag = mag[vnorm_pkg::MAG_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // Driver: presents queued vectors on the falling edge, holds them until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_vecs.size() != 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            vec_item_type v;
            v = pending_vecs.pop_front();
            req_valid        <= 1'b1;
            req_mode         <= v.mode;
            req_comp_x       <= v.cx;
            req_comp_y       <= v.cy;
            req_comp_z       <= v.cz;
            req_comp_w       <= v.cw;
            req_given_mag_sq <= v.given;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // Monitor: predicts on each accepted request, checks each accepted result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            vec_item_type v;
            v = '{req_mode, req_comp_x, req_comp_y, req_comp_z, req_comp_w, req_given_mag_sq};
            expected_units.push_back(normalize_vec(v));
         end
         if (csr_valid && csr_ready) margin <= csr_zero_margin;
         if (rsp_valid && !rsp_stall) begin
            if (expected_units.size() == 0) begin
               report_mismatch("unexpected result transaction", 1, 0);
            end else begin
               unit_result_type e;
               e = expected_units.pop_front();
               if (rsp_unit_x !== e.ux) report_mismatch("unit_x", rsp_unit_x, e.ux);
               if (rsp_unit_y !== e.uy) report_mismatch("unit_y", rsp_unit_y, e.uy);
               if (rsp_unit_z !== e.uz) report_mismatch("unit_z", rsp_unit_z, e.uz);
               if (rsp_unit_w !== e.uw) report_mismatch("unit_w", rsp_unit_w, e.uw);
               if (rsp_magnitude !== e.mag) report_mismatch("magnitude", rsp_magnitude, e.mag);
               if (rsp_is_zero !== e.zero) report_mismatch("is_zero", rsp_is_zero, e.zero);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout at cycle %0d", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 1)) - 16'sd1 + 16'($urandom_range(0, 1));
         3: return 16'($signed(8'($urandom())));   // small lengths near the margin
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic vec_item_type rand_vec();
      vec_item_type v;
      v.mode = 1'($urandom_range(1));
      v.cx = rand_comp();
      v.cy = rand_comp();
      v.cz = rand_comp();
      v.cw = rand_comp();
      case ($urandom_range(3))
         0: v.given = $urandom();
         1: v.given = $urandom_range(0, 65535);   // tiny lengths, heavy saturation
         2: v.given = 32'hFFFF_FFFF;
         default: v.given = $urandom_range(0, 1 << 20);
      endcase
      return v;
   endfunction

   // Waits until every expected result is back and the pipe has emptied.
   task automatic drain();
      while (pending_vecs.size() != 0 || req_valid || expected_units.size() != 0)
         @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_margin(logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_zero_margin <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_vec(logic mode, logic signed [15:0] x, y, z, w, logic [31:0] g);
      pending_vecs.push_back('{mode, x, y, z, w, g});
   endtask

   initial begin
      int idle_plan[3][2] = '{'{24, 49}, '{49, 24}, '{0, 0}};
      logic [15:0] margins[3] = '{16'd0, 16'hFFFF, 16'd300};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, both modes, exact zero, margin edge, saturation.
      add_vec(0, 0, 0, 0, 0, 0);                               // zero vector
      add_vec(0, 16'sh0001, 0, 0, 0, 0);                       // length at reset margin
      add_vec(0, 16'sh0002, 0, 0, 0, 0);                       // just above margin
      add_vec(0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
      add_vec(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      add_vec(0, 16'sh8000, 0, 0, 0, 32'hFFFF_FFFF);           // lone negative extreme
      add_vec(0, 16'sh0100, 16'shFF00, 16'sh0100, 16'shFF00, 0);
      add_vec(0, 16'sh0003, 16'shFFFD, 16'sh0001, 0, 0);       // small mixed-sign components
      add_vec(1, 16'sh7FFF, 16'sh8000, 16'sh1234, 16'shEDCC, 32'h0000_0100);
      add_vec(1, 16'sh7FFF, 16'sh8000, 0, 0, 32'hFFFF_FFFF);
      add_vec(1, 16'sh0100, 0, 0, 0, 32'h0000_0000);
      add_vec(1, 16'sh0100, 0, 0, 0, 32'h0001_0000);
      add_vec(1, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, 32'hAAAA_5555);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         write_margin(margins[ph]);
         send_idle_pct = idle_plan[ph][0];
         recv_idle_pct = idle_plan[ph][1];
         for (int n = 0; n < 460; n++) pending_vecs.push_back(rand_vec());
         if (ph == 1) begin
            // Sender holds off until every outstanding result is back.
            while (pending_vecs.size() > 230) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || expected_units.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end
      write_margin(16'd1);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/vnorm_pkg.sv
hdl/vnorm_sqrt.sv
hdl/vnorm_div.sv
hdl/vec4_normalize_core.sv
tb/testbench.sv
